// File: rtl/assert_macros.svh
// Assertion helper macros used by the RTL parser.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tppm_pkg.sv
// Types and constants for the TCP port payload mirror parser.
// No dependencies.
package tppm_pkg;

    // Frame limits and chunking
    localparam logic [11:0] MAX_FRAME    = 12'd2048;
    localparam int          CHUNK_BITS   = 8;
    localparam logic [11:0] CHUNK_BYTES  = 12'd256;
    localparam logic [8:0]  CHUNK_FULL   = 9'd256;

    // Header field positions within the frame
    localparam logic [11:0] POS_ETYPE_HI = 12'd12;
    localparam logic [11:0] POS_ETYPE_LO = 12'd13;
    localparam logic [11:0] POS_IP_VHL   = 12'd14;
    localparam logic [11:0] POS_IP_PROTO = 12'd23;
    localparam logic [11:0] POS_SRC_IP   = 12'd26;
    localparam logic [11:0] POS_DST_IP   = 12'd30;
    localparam logic [11:0] POS_L4_MIN   = 12'd34;
    localparam logic [11:0] ETH_HDR_LEN  = 12'd14;
    localparam logic [11:0] MIN_PSTART   = 12'd54;

    // Offsets within the TCP header
    localparam logic [11:0] TCP_DPORT_LO = 12'd3;
    localparam logic [11:0] TCP_DOFF     = 12'd12;

    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;
    localparam logic [15:0] MATCH_PORT_RST = 16'd8888;

    // Result kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // One result word
    typedef struct packed {
        logic        event_kind;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] tcp_sport;
        logic [15:0] tcp_dport;
        logic [11:0] pay_total;
        logic [10:0] chunk_offset;
        logic [8:0]  seg_bytes;
        logic [7:0]  payload_byte;
        logic [7:0]  byte_in_chunk;
        logic        chunk_end;
        logic        run_last;
    } t_result;

endpackage

// File: rtl/tcp_port_payload_mirror_parser.sv
// Ethernet/IPv4/TCP parser that mirrors the payload of one TCP port.
// Depends on tppm_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one frame byte per word,
//   with the frame length and a first-byte flag. Output channel
//   (o_out_valid / i_out_ready) carries result words: one header event
//   before the first payload byte of a passing frame, then one data word
//   per payload byte, tagged with its 256-byte chunk.
//   i_cfg_we / i_cfg_wdata write the matched destination port; write it
//   only while the block is idle.
// Timing:
//   A byte is parsed in the cycle it is accepted and its results sit in a
//   four-word result queue from the next cycle.
//   One byte per cycle is taken while the queue holds two words or fewer,
//   and a byte that also raises a header event pushes two words into it.
// Reset and stall:
//   Synchronous active-low reset empties the queue, drops any frame in
//   progress and restores the port to 8888. When the receiver stalls the
//   queue fills and o_in_ready falls at three queued words; nothing is lost.
module tcp_port_payload_mirror_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic [11:0] i_frame_len,
    input  logic        i_first_byte,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_event_kind,
    output logic [31:0] o_src_ip,
    output logic [31:0] o_dst_ip,
    output logic [15:0] o_tcp_sport,
    output logic [15:0] o_tcp_dport,
    output logic [11:0] o_pay_total,
    output logic [10:0] o_chunk_offset,
    output logic [8:0]  o_seg_bytes,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_byte_in_chunk,
    output logic        o_chunk_end,
    output logic        o_run_last
);

    `include "assert_macros.svh"

    // Parser state
    logic [15:0] r_match_port;
    logic [11:0] r_byte_pos,  n_byte_pos;
    logic        r_frame_ok,  n_frame_ok;
    logic [11:0] r_pstart,    n_pstart;
    logic [7:0]  r_etype_hi;
    logic [3:0]  r_ip_words;
    logic [31:0] r_src_ip;
    logic [31:0] r_dst_ip;
    logic [15:0] r_sport;
    logic [15:0] r_dport;

    // Result queue
    tppm_pkg::t_result r_queue [4];
    logic [1:0] r_head;
    logic [2:0] r_count, n_count;

    logic        in_acc;
    logic        out_acc;
    logic        cur_ok;
    logic [11:0] cur_pos;
    logic [11:0] cur_pstart;
    logic [11:0] eff_len;
    logic        in_range;
    logic [11:0] tcp_start;
    logic [11:0] tcp_rel;
    logic        in_tcp;
    logic        kill;
    logic        emit;
    logic        emit_hdr;
    logic [11:0] plen;
    logic [11:0] off;
    logic [10:0] coff;
    logic [11:0] rem;
    logic [8:0]  clen;
    logic [7:0]  bic;
    logic [1:0]  push_n;
    logic [1:0]  tail;
    logic [1:0]  tail_next;
    tppm_pkg::t_result hdr_res;
    tppm_pkg::t_result data_res;
    tppm_pkg::t_result head_res;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // Frame state as seen by this byte: a first byte restarts the frame
    assign cur_ok     = i_first_byte ? 1'b1  : r_frame_ok;
    assign cur_pos    = i_first_byte ? '0    : r_byte_pos;
    assign cur_pstart = i_first_byte ? '0    : r_pstart;
    assign eff_len    = (i_frame_len < tppm_pkg::MAX_FRAME) ? i_frame_len
                                                             : tppm_pkg::MAX_FRAME;
    assign in_range   = cur_ok && (cur_pos < eff_len);

    // Locate the TCP header behind the IPv4 options
    assign tcp_start = tppm_pkg::ETH_HDR_LEN + {6'd0, r_ip_words, 2'b00};
    assign tcp_rel   = cur_pos - tcp_start;
    assign in_tcp    = (cur_pos >= tppm_pkg::POS_L4_MIN) && (cur_pos >= tcp_start);

    // Header checks that drop the frame
    always_comb begin
        kill = 1'b0;
        if (cur_pos == tppm_pkg::POS_ETYPE_LO) begin
            kill = ({r_etype_hi, i_rx_byte} != tppm_pkg::ETYPE_IPV4);
        end else if (cur_pos == tppm_pkg::POS_IP_VHL) begin
            kill = (i_rx_byte[3:0] < tppm_pkg::MIN_HDR_WORDS);
        end else if (cur_pos == tppm_pkg::POS_IP_PROTO) begin
            kill = (i_rx_byte != tppm_pkg::PROTO_TCP);
        end else if (in_tcp && (tcp_rel == tppm_pkg::TCP_DPORT_LO)) begin
            kill = ({r_dport[7:0], i_rx_byte} != r_match_port);
        end else if (in_tcp && (tcp_rel == tppm_pkg::TCP_DOFF)) begin
            kill = (i_rx_byte[7:4] < tppm_pkg::MIN_HDR_WORDS);
        end
    end

    // Next frame state
    always_comb begin
        n_byte_pos = (cur_pos < tppm_pkg::MAX_FRAME) ? cur_pos + 12'd1 : cur_pos;
        n_frame_ok = cur_ok && !(in_range && kill);
        n_pstart   = cur_pstart;
        if (in_range && in_tcp && (tcp_rel == tppm_pkg::TCP_DOFF) && !kill) begin
            n_pstart = tcp_start + {6'd0, i_rx_byte[7:4], 2'b00};
        end
    end

    // Payload byte: work out its chunk
    assign emit     = in_range && (cur_pstart != '0) && (cur_pos >= cur_pstart);
    assign emit_hdr = emit && (cur_pos == cur_pstart);
    assign plen     = eff_len - cur_pstart;
    assign off      = cur_pos - cur_pstart;
    assign coff     = {off[10:tppm_pkg::CHUNK_BITS], {tppm_pkg::CHUNK_BITS{1'b0}}};
    assign rem      = plen - {1'b0, coff};
    assign clen     = (rem < tppm_pkg::CHUNK_BYTES) ? rem[8:0] : tppm_pkg::CHUNK_FULL;
    assign bic      = off[tppm_pkg::CHUNK_BITS-1:0];

    always_comb begin
        hdr_res               = '0;
        hdr_res.event_kind    = tppm_pkg::KIND_HEADER;
        hdr_res.src_ip        = r_src_ip;
        hdr_res.dst_ip        = r_dst_ip;
        hdr_res.tcp_sport     = r_sport;
        hdr_res.tcp_dport     = r_dport;
        hdr_res.pay_total     = plen;

        data_res               = '0;
        data_res.event_kind    = tppm_pkg::KIND_DATA;
        data_res.src_ip        = r_src_ip;
        data_res.dst_ip        = r_dst_ip;
        data_res.tcp_sport     = r_sport;
        data_res.tcp_dport     = r_dport;
        data_res.chunk_offset  = coff;
        data_res.seg_bytes     = clen;
        data_res.payload_byte  = i_rx_byte;
        data_res.byte_in_chunk = bic;
        data_res.chunk_end     = (({1'b0, bic} + 9'd1) == clen);
        data_res.run_last      = 1'b1;
    end

    // Queue bookkeeping
    assign push_n     = (in_acc && emit) ? (emit_hdr ? 2'd2 : 2'd1) : 2'd0;
    assign tail       = r_head + r_count[1:0];
    assign tail_next  = tail + 2'd1;
    assign n_count    = r_count + {1'b0, push_n} - {2'd0, out_acc};
    assign o_in_ready = (r_count <= 3'd2);
    assign o_out_valid = (r_count != 3'd0);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_port <= tppm_pkg::MATCH_PORT_RST;
            r_byte_pos   <= '0;
            r_frame_ok   <= 1'b0;
            r_pstart     <= '0;
            r_head       <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_match_port <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_byte_pos <= n_byte_pos;
                r_frame_ok <= n_frame_ok;
                r_pstart   <= n_pstart;
            end
            if (out_acc) begin
                r_head <= r_head + 2'd1;
            end
            r_count <= n_count;
        end
    end

    // Capture header fields as they stream past; clear them at a frame start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_first_byte)) begin
            r_etype_hi <= '0;
            r_ip_words <= '0;
            r_src_ip   <= '0;
            r_dst_ip   <= '0;
            r_sport    <= '0;
            r_dport    <= '0;
        end else if (in_acc && in_range) begin
            if (cur_pos == tppm_pkg::POS_ETYPE_HI) begin
                r_etype_hi <= i_rx_byte;
            end
            if (cur_pos == tppm_pkg::POS_IP_VHL) begin
                r_ip_words <= i_rx_byte[3:0];
            end
            if ((cur_pos >= tppm_pkg::POS_SRC_IP) && (cur_pos < tppm_pkg::POS_DST_IP)) begin
                r_src_ip <= {r_src_ip[23:0], i_rx_byte};
            end
            if ((cur_pos >= tppm_pkg::POS_DST_IP) && (cur_pos < tppm_pkg::POS_L4_MIN)) begin
                r_dst_ip <= {r_dst_ip[23:0], i_rx_byte};
            end
            if (in_tcp && (tcp_rel < 12'd2)) begin
                r_sport <= {r_sport[7:0], i_rx_byte};
            end
            if (in_tcp && (tcp_rel >= 12'd2) && (tcp_rel <= tppm_pkg::TCP_DPORT_LO)) begin
                r_dport <= {r_dport[7:0], i_rx_byte};
            end
        end
    end

    // Push results: header event first, then the data word
    always_ff @(posedge i_clk) begin
        if (in_acc && emit) begin
            if (emit_hdr) begin
                r_queue[tail]      <= hdr_res;
                r_queue[tail_next] <= data_res;
            end else begin
                r_queue[tail]      <= data_res;
            end
        end
    end

    // Drive the head word
    assign head_res        = r_queue[r_head];
    assign o_event_kind    = head_res.event_kind;
    assign o_src_ip        = head_res.src_ip;
    assign o_dst_ip        = head_res.dst_ip;
    assign o_tcp_sport     = head_res.tcp_sport;
    assign o_tcp_dport     = head_res.tcp_dport;
    assign o_pay_total     = head_res.pay_total;
    assign o_chunk_offset  = head_res.chunk_offset;
    assign o_seg_bytes     = head_res.seg_bytes;
    assign o_payload_byte  = head_res.payload_byte;
    assign o_byte_in_chunk = head_res.byte_in_chunk;
    assign o_chunk_end     = head_res.chunk_end;
    assign o_run_last      = head_res.run_last;

    // Checks
    `ASSERT_IMPLIES(a_queue_bound, i_clk, i_rst_n, 1'b1, r_count <= 3'd4,
        "result queue over capacity")
    `ASSERT_NEXT(a_hdr_then_data, i_clk, i_rst_n,
        out_acc && (o_event_kind == tppm_pkg::KIND_HEADER),
        o_out_valid && (o_event_kind == tppm_pkg::KIND_DATA),
        "header event not followed by its data word")
    `ASSERT_IMPLIES(a_pstart_min, i_clk, i_rst_n, r_pstart != '0,
        r_pstart >= tppm_pkg::MIN_PSTART, "payload start inside minimum headers")
    `ASSERT_NEXT(a_first_restart, i_clk, i_rst_n, in_acc && i_first_byte,
        r_byte_pos == 12'd1 && r_pstart == '0, "first byte did not restart frame")

endmodule

// File: dv/testbench.sv
// Self-checking bench for tcp_port_payload_mirror_parser: frames are parsed in
// a behavioural copy of the block and every result word is checked in order.
// Depends on tppm_pkg (result type, header constants) and the RTL top.
module testbench;

    localparam int          HALF_PERIOD  = 10;
    localparam int          RESET_CYCLES = 8;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          PHASE_ITEMS  = 125;
    localparam int          LONG_HOLD    = 400;
    localparam int          REPORT_MAX   = 10;
    localparam int          OVER_CAP_LEN = 3000;
    localparam logic [3:0]  IP_VERSION   = 4'd4;
    localparam logic [15:0] ETYPE_IPV6   = 16'h86DD;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;

    // Behavioural parser plus the queue of words it has predicted
    class mirror_scoreboard;
        logic [15:0] port_to_mirror;
        int          byte_count;
        logic        frame_live;
        logic [15:0] etype;
        logic [3:0]  ip_words;
        logic [7:0]  proto;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] l4_sport;
        logic [15:0] l4_dport;
        logic [3:0]  tcp_words;
        int          pay_start;
        tppm_pkg::t_result mirror_words_due[$];
        int          mismatches;

        function new();
            port_to_mirror = tppm_pkg::MATCH_PORT_RST;
            mismatches = 0;
            drop_frame();
        endfunction

        function void drop_frame();
            byte_count = 0;
            frame_live = 1'b0;
            etype = '0;
            ip_words = '0;
            proto = '0;
            src_ip = '0;
            dst_ip = '0;
            l4_sport = '0;
            l4_dport = '0;
            tcp_words = '0;
            pay_start = 0;
        endfunction

        function int pending();
            return mirror_words_due.size();
        endfunction

        // Advance the parse by one accepted byte and queue the words it causes
        function void parse_byte(logic [7:0] b, logic [11:0] flen, logic first);
            int      pos;
            int      eff;
            int      tcp_start;
            int      rel;
            int      plen;
            int      off;
            int      coff;
            int      rem;
            int      clen;
            int      bic;
            tppm_pkg::t_result w;
            if (first) begin
                drop_frame();
                frame_live = 1'b1;
            end
            pos = byte_count;
            if (byte_count < int'(tppm_pkg::MAX_FRAME))
                byte_count++;
            eff = (int'(flen) < int'(tppm_pkg::MAX_FRAME)) ? int'(flen)
                                                            : int'(tppm_pkg::MAX_FRAME);
            if (!frame_live || pos >= eff)
                return;

            // Header fields at fixed and IHL-relative positions
            if (pos == int'(tppm_pkg::POS_ETYPE_HI)) begin
                etype = {b, 8'h00};
            end else if (pos == int'(tppm_pkg::POS_ETYPE_LO)) begin
                etype[7:0] = b;
                if (etype != tppm_pkg::ETYPE_IPV4)
                    frame_live = 1'b0;
            end else if (pos == int'(tppm_pkg::POS_IP_VHL)) begin
                ip_words = b[3:0];
                if (ip_words < tppm_pkg::MIN_HDR_WORDS)
                    frame_live = 1'b0;
            end else if (pos == int'(tppm_pkg::POS_IP_PROTO)) begin
                proto = b;
                if (proto != tppm_pkg::PROTO_TCP)
                    frame_live = 1'b0;
            end else if (pos >= int'(tppm_pkg::POS_SRC_IP) &&
                         pos < int'(tppm_pkg::POS_DST_IP)) begin
                src_ip = {src_ip[23:0], b};
            end else if (pos >= int'(tppm_pkg::POS_DST_IP) &&
                         pos < int'(tppm_pkg::POS_L4_MIN)) begin
                dst_ip = {dst_ip[23:0], b};
            end else if (pos >= int'(tppm_pkg::POS_L4_MIN)) begin
                tcp_start = int'(tppm_pkg::ETH_HDR_LEN) + 4 * int'(ip_words);
                if (pos >= tcp_start) begin
                    rel = pos - tcp_start;
                    if (rel <= 1) begin
                        l4_sport = {l4_sport[7:0], b};
                    end else if (rel <= int'(tppm_pkg::TCP_DPORT_LO)) begin
                        l4_dport = {l4_dport[7:0], b};
                        if (rel == int'(tppm_pkg::TCP_DPORT_LO) &&
                            l4_dport != port_to_mirror)
                            frame_live = 1'b0;
                    end else if (rel == int'(tppm_pkg::TCP_DOFF)) begin
                        tcp_words = b[7:4];
                        if (tcp_words < tppm_pkg::MIN_HDR_WORDS)
                            frame_live = 1'b0;
                        else
                            pay_start = tcp_start + 4 * int'(tcp_words);
                    end
                end
            end

            if (!frame_live || pay_start == 0 || pos < pay_start)
                return;

            // Payload byte: header event first on the opening byte
            plen = eff - pay_start;
            off  = pos - pay_start;
            coff = (off / int'(tppm_pkg::CHUNK_BYTES)) * int'(tppm_pkg::CHUNK_BYTES);
            rem  = plen - coff;
            clen = (rem < int'(tppm_pkg::CHUNK_BYTES)) ? rem : int'(tppm_pkg::CHUNK_BYTES);
            bic  = off - coff;
            w = '0;
            w.src_ip    = src_ip;
            w.dst_ip    = dst_ip;
            w.tcp_sport = l4_sport;
            w.tcp_dport = l4_dport;
            if (pos == pay_start) begin
                w.event_kind = tppm_pkg::KIND_HEADER;
                w.pay_total  = 12'(plen);
                mirror_words_due.push_back(w);
            end
            w.event_kind    = tppm_pkg::KIND_DATA;
            w.pay_total     = '0;
            w.chunk_offset  = 11'(coff);
            w.seg_bytes     = 9'(clen);
            w.payload_byte  = b;
            w.byte_in_chunk = 8'(bic);
            w.chunk_end     = (bic + 1 == clen);
            w.run_last      = 1'b1;
            mirror_words_due.push_back(w);
        endfunction

        function string word_text(tppm_pkg::t_result w);
            return $sformatf({"kind=%0d sip=%h dip=%h sport=%0d dport=%0d plen=%0d ",
                              "coff=%0d clen=%0d byte=%h bic=%0d end=%0d last=%0d"},
                             w.event_kind, w.src_ip, w.dst_ip, w.tcp_sport, w.tcp_dport,
                             w.pay_total, w.chunk_offset, w.seg_bytes, w.payload_byte,
                             w.byte_in_chunk, w.chunk_end, w.run_last);
        endfunction

        // Compare one accepted result word with the oldest prediction
        function void check_word(tppm_pkg::t_result got);
            tppm_pkg::t_result exp;
            if (mirror_words_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected word: %s", word_text(got));
                return;
            end
            exp = mirror_words_due.pop_front();
            if (got.event_kind !== exp.event_kind || got.src_ip !== exp.src_ip ||
                got.dst_ip !== exp.dst_ip || got.tcp_sport !== exp.tcp_sport ||
                got.tcp_dport !== exp.tcp_dport || got.pay_total !== exp.pay_total ||
                got.chunk_offset !== exp.chunk_offset || got.seg_bytes !== exp.seg_bytes ||
                got.payload_byte !== exp.payload_byte ||
                got.byte_in_chunk !== exp.byte_in_chunk ||
                got.chunk_end !== exp.chunk_end || got.run_last !== exp.run_last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("mismatch expected: %s", word_text(exp));
                    $display("mismatch actual:   %s", word_text(got));
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte;
    logic [11:0] i_frame_len;
    logic        i_first_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_event_kind;
    logic [31:0] o_src_ip;
    logic [31:0] o_dst_ip;
    logic [15:0] o_tcp_sport;
    logic [15:0] o_tcp_dport;
    logic [11:0] o_pay_total;
    logic [10:0] o_chunk_offset;
    logic [8:0]  o_seg_bytes;
    logic [7:0]  o_payload_byte;
    logic [7:0]  o_byte_in_chunk;
    logic        o_chunk_end;
    logic        o_run_last;

    mirror_scoreboard  words_sb;
    tppm_pkg::t_result seen_word;
    logic [7:0]        frame_bytes[$];
    logic [15:0]       cur_port = tppm_pkg::MATCH_PORT_RST;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                hold_req = 0;
    int                hold_left = 0;
    int                frame_items = 0;
    int                cycle_count = 0;

    tcp_port_payload_mirror_parser i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .i_frame_len    (i_frame_len),
        .i_first_byte   (i_first_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_kind   (o_event_kind),
        .o_src_ip       (o_src_ip),
        .o_dst_ip       (o_dst_ip),
        .o_tcp_sport    (o_tcp_sport),
        .o_tcp_dport    (o_tcp_dport),
        .o_pay_total    (o_pay_total),
        .o_chunk_offset (o_chunk_offset),
        .o_seg_bytes    (o_seg_bytes),
        .o_payload_byte (o_payload_byte),
        .o_byte_in_chunk(o_byte_in_chunk),
        .o_chunk_end    (o_chunk_end),
        .o_run_last     (o_run_last)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Note accepted input words and check accepted result words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                words_sb.parse_byte(i_rx_byte, i_frame_len, i_first_byte);
            if (o_out_valid && i_out_ready) begin
                seen_word = {o_event_kind, o_src_ip, o_dst_ip, o_tcp_sport, o_tcp_dport,
                             o_pay_total, o_chunk_offset, o_seg_bytes, o_payload_byte,
                             o_byte_in_chunk, o_chunk_end, o_run_last};
                words_sb.check_word(seen_word);
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Lay out one Ethernet/IPv4/TCP frame with random filler
    function automatic void build_frame(input logic [15:0] etype, input logic [3:0] ip_ver,
                                        input logic [3:0] ihl, input logic [7:0] proto,
                                        input logic [15:0] dport, input logic [3:0] doff,
                                        input int npay);
        int          ip_len;
        int          tcp_len;
        logic [15:0] sport;
        logic [31:0] sip;
        logic [31:0] dip;
        ip_len  = (ihl < tppm_pkg::MIN_HDR_WORDS) ? 20 : 4 * int'(ihl);
        tcp_len = (doff < tppm_pkg::MIN_HDR_WORDS) ? 20 : 4 * int'(doff);
        sport = 16'($urandom);
        sip   = $urandom;
        dip   = $urandom;
        frame_bytes.delete();
        repeat (12) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(etype[15:8]);
        frame_bytes.push_back(etype[7:0]);
        frame_bytes.push_back({ip_ver, ihl});
        repeat (8) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(proto);
        repeat (2) frame_bytes.push_back(8'($urandom));
        for (int i = 3; i >= 0; i--) frame_bytes.push_back(sip[8*i +: 8]);
        for (int i = 3; i >= 0; i--) frame_bytes.push_back(dip[8*i +: 8]);
        repeat (ip_len - 20) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(sport[15:8]);
        frame_bytes.push_back(sport[7:0]);
        frame_bytes.push_back(dport[15:8]);
        frame_bytes.push_back(dport[7:0]);
        repeat (8) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back({doff, 4'($urandom)});
        repeat (7 + tcp_len - 20) frame_bytes.push_back(8'($urandom));
        repeat (npay) frame_bytes.push_back(8'($urandom));
    endfunction

    // Offer one word; return at the edge that accepts it
    task automatic send_byte(input logic [7:0] b, input logic [11:0] flen, input logic first);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_rx_byte    <= b;
        i_frame_len  <= flen;
        i_first_byte <= first;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Send nsend bytes of the built frame, padding with junk past its end
    task automatic send_frame(input int flen, input int nsend);
        logic [7:0] b;
        for (int i = 0; i < nsend; i++) begin
            b = (i < frame_bytes.size()) ? frame_bytes[i] : 8'($urandom);
            send_byte(b, 12'(flen), i == 0);
        end
        frame_items += nsend;
    endtask

    task automatic send_whole();
        send_frame(frame_bytes.size(), frame_bytes.size());
    endtask

    // Drop valid, wait out every due word and the pipeline
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (words_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_port(input logic [15:0] port);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= port;
        words_sb.port_to_mirror = port;
        cur_port = port;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One random frame: mostly passing, the rest broken in one way or noise
    task automatic random_frame();
        int          kind;
        logic [3:0]  ihl;
        logic [3:0]  doff;
        int          npay;
        int          total;
        int          flen;
        int          nsend;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [15:0] dport;
        logic [3:0]  ver;
        kind  = $urandom_range(99);
        ihl   = 4'($urandom_range(15, 5));
        doff  = 4'($urandom_range(15, 5));
        npay  = ($urandom_range(19) == 0) ? $urandom_range(600, 200) : $urandom_range(40, 1);
        etype = tppm_pkg::ETYPE_IPV4;
        proto = tppm_pkg::PROTO_TCP;
        dport = cur_port;
        ver   = ($urandom_range(9) == 0) ? 4'($urandom) : IP_VERSION;
        if (kind >= 98) begin
            repeat ($urandom_range(6, 1))
                send_byte(8'($urandom), 12'($urandom_range(2048)), 1'b0);
            return;
        end
        if (kind >= 70 && kind <= 73) etype = 16'($urandom);
        if (kind >= 74 && kind <= 77) proto = 8'($urandom);
        if (kind >= 78 && kind <= 80) ihl = 4'($urandom_range(4));
        if (kind >= 81 && kind <= 83) doff = 4'($urandom_range(4));
        if (kind >= 84 && kind <= 87) dport = cur_port ^ 16'($urandom_range(65535, 1));
        if (kind >= 88 && kind <= 90) npay = 0;
        build_frame(etype, ver, ihl, proto, dport, doff, npay);
        total = frame_bytes.size();
        flen  = total;
        nsend = total;
        if (kind >= 91 && kind <= 93) nsend = $urandom_range(total - 1, 1);
        if (kind >= 94 && kind <= 95) flen = $urandom_range(total - 1);
        if (kind >= 96 && kind <= 97) nsend = total + $urandom_range(8, 1);
        send_frame(flen, nsend);
    endtask

    initial begin
        int total;
        int send_idle_tab[4];
        int recv_stall_tab[4];
        logic [15:0] port_tab[4];
        send_idle_tab  = '{0, 80, 0, 19};
        recv_stall_tab = '{0, 0, 80, 19};
        port_tab       = '{16'd0, 16'hFFFF, 16'($urandom), tppm_pkg::MATCH_PORT_RST};
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_rx_byte    = '0;
        i_frame_len  = '0;
        i_first_byte = 1'b0;
        i_out_ready  = 1'b0;
        words_sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Bytes before any frame start are ignored
        repeat (3) send_byte(8'($urandom), 12'd60, 1'b0);
        // Passing frames: shortest and longest headers, version nibble ignored
        build_frame(tppm_pkg::ETYPE_IPV4, IP_VERSION, 4'd5, tppm_pkg::PROTO_TCP,
                    cur_port, 4'd5, 1);
        send_whole();
        build_frame(tppm_pkg::ETYPE_IPV4, 4'd0, 4'd15, tppm_pkg::PROTO_TCP,
                    cur_port, 4'd15, 3);
        send_whole();
        // Each rejection: EtherType, protocol, short IHL, short data offset, port
        build_frame(ETYPE_IPV6, IP_VERSION, 4'd5, tppm_pkg::PROTO_TCP, cur_port, 4'd5, 4);
        send_whole();
        build_frame(tppm_pkg::ETYPE_IPV4, IP_VERSION, 4'd5, PROTO_UDP, cur_port, 4'd5, 4);
        send_whole();
        build_frame(tppm_pkg::ETYPE_IPV4, IP_VERSION, 4'd4, tppm_pkg::PROTO_TCP,
                    cur_port, 4'd5, 4);
        send_whole();
        build_frame(tppm_pkg::ETYPE_IPV4, IP_VERSION, 4'd5, tppm_pkg::PROTO_TCP,
                    cur_port, 4'd4, 4);
        send_whole();
        build_frame(tppm_pkg::ETYPE_IPV4, IP_VERSION, 4'd5, tppm_pkg::PROTO_TCP,
                    cur_port + 16'd1, 4'd5, 4);
        send_whole();
        // Empty payload, and a frame length that ends inside the headers
        build_frame(tppm_pkg::ETYPE_IPV4, IP_VERSION, 4'd5, tppm_pkg::PROTO_TCP,
                    cur_port, 4'd5, 0);
        send_whole();
        build_frame(tppm_pkg::ETYPE_IPV4, IP_VERSION, 4'd5, tppm_pkg::PROTO_TCP,
                    cur_port, 4'd5, 6);
        send_frame(40, frame_bytes.size());
        // New frame start in mid-frame, then junk past the frame end
        build_frame(tppm_pkg::ETYPE_IPV4, IP_VERSION, 4'd5, tppm_pkg::PROTO_TCP,
                    cur_port, 4'd5, 6);
        send_frame(frame_bytes.size(), 30);
        build_frame(tppm_pkg::ETYPE_IPV4, IP_VERSION, 4'd6, tppm_pkg::PROTO_TCP,
                    cur_port, 4'd7, 2);
        send_frame(frame_bytes.size(), frame_bytes.size() + 4);
        // Frame length shrinks half way through the payload
        build_frame(tppm_pkg::ETYPE_IPV4, IP_VERSION, 4'd5, tppm_pkg::PROTO_TCP,
                    cur_port, 4'd5, 10);
        total = frame_bytes.size();
        for (int i = 0; i < total; i++)
            send_byte(frame_bytes[i], 12'(i < total - 5 ? total : total - 3), i == 0);
        frame_items += total;
        // Zero frame length, then a frame length above the cap
        build_frame(tppm_pkg::ETYPE_IPV4, IP_VERSION, 4'd5, tppm_pkg::PROTO_TCP,
                    cur_port, 4'd5, 8);
        send_frame(0, frame_bytes.size());
        build_frame(tppm_pkg::ETYPE_IPV4, IP_VERSION, 4'd5, tppm_pkg::PROTO_TCP,
                    cur_port, 4'd5, 20);
        send_frame(OVER_CAP_LEN, frame_bytes.size());

        // Random phases, each under its own port and idling mix
        for (int p = 0; p < 4; p++) begin
            drain();
            write_port(port_tab[p]);
            send_idle_pct  = send_idle_tab[p];
            recv_stall_pct = recv_stall_tab[p];
            if (p == 0) begin
                @(posedge i_clk);
                hold_req = LONG_HOLD;
            end
            frame_items = 0;
            while (frame_items < PHASE_ITEMS)
                random_frame();
        end

        drain();
        if (words_sb.mismatches == 0 && words_sb.pending() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/tppm_pkg.sv
rtl/tcp_port_payload_mirror_parser.sv
dv/testbench.sv
